[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros shared by the checker files.
// Every assertion is clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition must never be seen at a rising edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
	`ASSERT_CLK(label, !(cond), msg)

`endif

[rtl/cfle_pkg.sv]
// ----------------------------------------------------------------------------
// cfle_pkg
// Types, constants and helper functions of the CRC framed line encoder.
// ----------------------------------------------------------------------------
package cfle_pkg;

	// Width of the payload byte counter, which saturates at its top value.
	localparam int CountWidth = 16;
	// Width of the length limit register.
	localparam int LenWidth = 16;
	localparam logic [LenWidth-1:0] MaxLenReset = 16'd1016;

	// CRC-16/CCITT-FALSE.
	localparam logic [15:0] CrcInit = 16'hFFFF;
	localparam logic [15:0] CrcPoly = 16'h1021;

	// Longest list of output words one input word can cause.
	localparam int ListDepth = 8;
	localparam int ListCntWidth = $clog2(ListDepth + 1);

	// Characters of the framed line.
	localparam logic [7:0] CharStart = 8'h40;
	localparam logic [7:0] CharStar  = 8'h2A;
	localparam logic [7:0] CharNl    = 8'h0A;

	// One output word.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       end_of_frame;
		logic       frame_error;
	} res_t;

	// Framing state carried from one input word to the next.
	typedef struct packed {
		logic [15:0]           crc;
		logic                  in_frame;
		logic [CountWidth-1:0] count;
		logic                  discarding;
	} frame_state_t;

	// One byte of CRC, MSB first, eight shift steps.
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CrcPoly;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

	// Upper-case hex character of one nibble.
	function automatic logic [7:0] hex_char(input logic [3:0] n);
		logic [7:0] ch;
		if (n < 4'd10) begin
			ch = 8'h30 + {4'h0, n};
		end else begin
			ch = 8'h37 + {4'h0, n};
		end
		return ch;
	endfunction

endpackage

[rtl/cfle_step.sv]
// ----------------------------------------------------------------------------
// cfle_step
// Combinational framing step: from the current state and one payload byte it
// builds the list of output words and the next framing state.
// ----------------------------------------------------------------------------
module cfle_step (
	input  cfle_pkg::frame_state_t                        st,
	input  logic [cfle_pkg::LenWidth-1:0]                 max_len,
	input  logic [7:0]                                    data_byte,
	input  logic                                          last_byte,
	output cfle_pkg::frame_state_t                        st_next,
	output cfle_pkg::res_t [cfle_pkg::ListDepth-1:0]      list,
	output logic [cfle_pkg::ListCntWidth-1:0]             list_cnt
);
	import cfle_pkg::*;

	logic [15:0]          crc_next;
	logic                 too_long;
	logic                 first;
	res_t [ListDepth:0]   full;

	assign crc_next = crc_byte(st.crc, data_byte);
	assign too_long = 32'(st.count) >= 32'(max_len);
	assign first    = !st.in_frame;

	// Whole line of a frame that starts and ends with this byte.
	always_comb begin
		full[0] = '{out_byte: CharStart, end_of_frame: 1'b0, frame_error: 1'b0};
		full[1] = '{out_byte: data_byte, end_of_frame: 1'b0, frame_error: 1'b0};
		full[2] = '{out_byte: CharStar, end_of_frame: 1'b0, frame_error: 1'b0};
		full[3] = '{out_byte: hex_char(crc_next[15:12]), end_of_frame: 1'b0, frame_error: 1'b0};
		full[4] = '{out_byte: hex_char(crc_next[11:8]), end_of_frame: 1'b0, frame_error: 1'b0};
		full[5] = '{out_byte: hex_char(crc_next[7:4]), end_of_frame: 1'b0, frame_error: 1'b0};
		full[6] = '{out_byte: hex_char(crc_next[3:0]), end_of_frame: 1'b0, frame_error: 1'b0};
		full[7] = '{out_byte: CharNl, end_of_frame: 1'b1, frame_error: 1'b0};
		full[8] = '0;
	end

	// Drop the start character when the frame is already open; over the limit, entry zero becomes the error word.
	always_comb begin
		for (int i = 0; i < ListDepth; i++) begin
			list[i] = first ? full[i] : full[i+1];
		end
		if (too_long) begin
			list[0] = '{out_byte: 8'h00, end_of_frame: 1'b1, frame_error: 1'b1};
		end
	end

	// Word count and next state.
	always_comb begin
		st_next  = st;
		list_cnt = '0;
		if (st.discarding) begin
			if (last_byte) begin
				st_next.discarding = 1'b0;
			end
		end else if (too_long) begin
			list_cnt           = ListCntWidth'(1);
			st_next.crc        = CrcInit;
			st_next.in_frame   = 1'b0;
			st_next.count      = '0;
			st_next.discarding = !last_byte;
		end else begin
			list_cnt = ListCntWidth'(1) + (first ? ListCntWidth'(1) : '0)
				+ (last_byte ? ListCntWidth'(6) : '0);
			if (last_byte) begin
				st_next.crc      = CrcInit;
				st_next.in_frame = 1'b0;
				st_next.count    = '0;
			end else begin
				st_next.crc      = crc_next;
				st_next.in_frame = 1'b1;
				if (st.count != '1) begin
					st_next.count = st.count + 1'b1;
				end
			end
		end
	end

endmodule

[rtl/crc_framed_line_encoder_core.sv]
// ----------------------------------------------------------------------------
// crc_framed_line_encoder_core
// Frames payload bytes as a text line with a CRC-16/CCITT-FALSE trailer.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream carries payload bytes in s_axis_tdata; s_axis_tlast marks
// the last byte of a payload. The master stream sends the line one character
// per word: '@', the payload bytes, '*', four upper-case hex CRC digits and a
// newline with m_axis_tlast set. A payload longer than the limit written on
// the cfg channel gives one word with tuser set, tlast set and zero data, and
// the rest of that payload is dropped. Write cfg only while the block is idle.
// Each input word is held in an input register, then expanded into a list of
// up to eight output words that drains at one word per cycle while the
// receiver takes them. A byte in the middle of a frame gives one word, so
// such bytes stream at one per cycle while the receiver keeps up; the first
// byte gives two words and the last byte seven, or eight if it opens the frame.
// While the receiver stalls, the list and one waiting input word are held and
// s_axis_tready drops. Reset empties both and restores the limit to 1016.
// ----------------------------------------------------------------------------
module crc_framed_line_encoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
	output logic        m_axis_tlast,
	output logic        m_axis_tuser,   // [0] frame_error
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);
	import cfle_pkg::*;

	logic                     valid_s1;
	logic [7:0]               data_s1;
	logic                     last_s1;
	logic [LenWidth-1:0]      max_len_q;
	frame_state_t             st_q;
	frame_state_t             st_next;
	res_t [ListDepth-1:0]     list_q;
	res_t [ListDepth-1:0]     list_new;
	logic [ListCntWidth-1:0]  cnt_q;
	logic [ListCntWidth-1:0]  cnt_new;
	logic                     pop;
	logic                     list_free;
	logic                     load;

	// Output list drains from entry zero.
	assign m_axis_tvalid = cnt_q != '0;
	assign m_axis_tdata  = list_q[0].out_byte;
	assign m_axis_tlast  = list_q[0].end_of_frame;
	assign m_axis_tuser  = list_q[0].frame_error;
	assign pop           = m_axis_tvalid && m_axis_tready;

	// The list takes a new item once its last word leaves.
	assign list_free     = (cnt_q == '0) || (cnt_q == ListCntWidth'(1) && pop);
	assign load          = valid_s1 && list_free;
	assign s_axis_tready = !valid_s1 || load;
	assign cfg_ready     = 1'b1;

	cfle_step u_step (
		.st        (st_q),
		.max_len   (max_len_q),
		.data_byte (data_s1),
		.last_byte (last_s1),
		.st_next   (st_next),
		.list      (list_new),
		.list_cnt  (cnt_new)
	);

	// Limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MaxLenReset;
		end else if (cfg_valid && cfg_ready) begin
			max_len_q <= cfg_data;
		end
	end

	// Input register and framing state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			st_q     <= '{crc: CrcInit, in_frame: 1'b0, count: '0, discarding: 1'b0};
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (load) begin
				st_q <= st_next;
			end
		end
	end

	// Input payload, no reset needed.
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			data_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// Output word count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= cnt_new;
		end else if (pop) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Output word list: loaded whole, shifted down one entry per word taken.
	always_ff @(posedge clk) begin
		if (load) begin
			list_q <= list_new;
		end else if (pop) begin
			for (int i = 0; i < ListDepth - 1; i++) begin
				list_q[i] <= list_q[i+1];
			end
		end
	end

endmodule

[rtl/cfle_checker.sv]
// ----------------------------------------------------------------------------
// cfle_checker
// Port-level checks of the CRC framed line encoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cfle_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [7:0]  m_axis_tdata,
	input logic        m_axis_tlast,
	input logic        m_axis_tuser
);

	// A stalled output word holds its contents.
	`ASSERT_CLK(a_out_hold, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid
		&& $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser)),
		"output word changed while stalled")

	// An error word carries zero data and closes the frame.
	`ASSERT_CLK(a_err_word, (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == 8'h00 && m_axis_tlast), "bad error word")

	// A normal frame ends on a newline.
	`ASSERT_CLK(a_line_end, (m_axis_tvalid && m_axis_tlast && !m_axis_tuser) |->
		(m_axis_tdata == 8'h0A), "frame end is not a newline")

	// With no output pending, the input side is never held off.
	`ASSERT_NEVER(a_no_stall, !m_axis_tvalid && !s_axis_tready, "input stalled with empty output")

endmodule

bind crc_framed_line_encoder_core cfle_checker u_cfle_checker (.*);

[tb/crc_framed_line_encoder_core_tb.sv]
// ----------------------------------------------------------------------------
// crc_framed_line_encoder_core_tb
// Self-checking bench for the CRC framed line encoder. Payload bytes go in on
// the slave stream. A behavioral copy of the framer builds the line that each
// accepted byte should produce: the start mark, the byte, then the star, the
// CRC digits and the newline, or the too-long error word. Every word taken
// from the master stream is compared field by field with the oldest entry in
// that list. Directed frames cover the reset limit, exact-limit and over-limit
// payloads and the single byte frame. Random frames then run under three
// handshake idling mixes and several length limits.
// ----------------------------------------------------------------------------
module crc_framed_line_encoder_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cfle_pkg::*;

	localparam int HalfPeriod = 4;
	localparam int ResetCycles = 10;
	// Cycles allowed for the pipeline to settle once the list is empty.
	localparam int SettleCycles = 16;
	// Cycles without any accepted word before the run is declared hung.
	localparam int HangLimit = 3000;
	localparam int MaxReports = 10;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;
	logic        m_axis_tlast;
	logic        m_axis_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = 16'h0000;

	// Copy of the framer state and of the length limit.
	logic [15:0]           line_crc;
	logic                  line_open;
	logic [CountWidth-1:0] line_count;
	logic                  line_dropping;
	logic [LenWidth-1:0]   line_limit;

	// Characters still owed by the block, oldest first.
	res_t pending_chars[$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int mismatches = 0;
	int chars_checked = 0;
	int bytes_sent = 0;
	int lines_closed = 0;
	int frames_cut = 0;
	int limits_used = 0;
	int quiet_cycles = 0;

	crc_framed_line_encoder_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always #HalfPeriod clk = ~clk;

	// CRC-16 update, one bit at a time with the feedback taken from the top.
	function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		logic        fb;
		c = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = c[15] ^ b[i];
			c = {c[14:0], 1'b0} ^ (fb ? 16'h1021 : 16'h0000);
		end
		return c;
	endfunction

	// Upper-case ASCII digit of one nibble.
	function automatic logic [7:0] nibble_ascii(input logic [3:0] n);
		logic [7:0] ch;
		if (n > 4'd9) begin
			ch = "A" + 8'(n - 4'd10);
		end else begin
			ch = "0" + 8'(n);
		end
		return ch;
	endfunction

	function automatic void owe_char(input logic [7:0] ch, input logic eof, input logic err);
		res_t w;
		w.out_byte = ch;
		w.end_of_frame = eof;
		w.frame_error = err;
		pending_chars.push_back(w);
	endfunction

	function automatic void restart_line();
		line_crc = 16'hFFFF;
		line_open = 1'b0;
		line_count = '0;
	endfunction

	// Works out the characters caused by one accepted payload byte.
	function automatic void frame_byte(input logic [7:0] b, input logic last);
		if (line_dropping) begin
			if (last) begin
				line_dropping = 1'b0;
			end
			return;
		end
		// Over the limit: one error word closes the frame.
		if (line_count >= line_limit) begin
			owe_char(8'h00, 1'b1, 1'b1);
			restart_line();
			line_dropping = !last;
			frames_cut++;
			return;
		end
		if (!line_open) begin
			owe_char(CharStart, 1'b0, 1'b0);
			line_open = 1'b1;
		end
		owe_char(b, 1'b0, 1'b0);
		line_crc = crc16_update(line_crc, b);
		if (line_count != '1) begin
			line_count++;
		end
		if (last) begin
			owe_char(CharStar, 1'b0, 1'b0);
			owe_char(nibble_ascii(line_crc[15:12]), 1'b0, 1'b0);
			owe_char(nibble_ascii(line_crc[11:8]), 1'b0, 1'b0);
			owe_char(nibble_ascii(line_crc[7:4]), 1'b0, 1'b0);
			owe_char(nibble_ascii(line_crc[3:0]), 1'b0, 1'b0);
			owe_char(CharNl, 1'b1, 1'b0);
			restart_line();
			lines_closed++;
		end
	endfunction

	// Receiver back-pressure, redrawn every falling edge.
	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Compares each accepted output word with the oldest owed character.
	always @(posedge clk) begin
		res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			chars_checked++;
			if (pending_chars.size() == 0) begin
				mismatches++;
				if (mismatches <= MaxReports) begin
					$display("%0t: unexpected word data=%h last=%b user=%b", $realtime,
						m_axis_tdata, m_axis_tlast, m_axis_tuser);
				end
			end else begin
				want = pending_chars.pop_front();
				if (m_axis_tdata !== want.out_byte || m_axis_tlast !== want.end_of_frame ||
						m_axis_tuser !== want.frame_error) begin
					mismatches++;
					if (mismatches <= MaxReports) begin
						$display("%0t: word %0d data %h/%h last %b/%b user %b/%b (want/got)",
							$realtime, chars_checked, want.out_byte, m_axis_tdata,
							want.end_of_frame, m_axis_tlast, want.frame_error, m_axis_tuser);
					end
				end
			end
		end
	end

	// Hang detection: no word moves on any channel for too long.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= HangLimit) begin
			$display("%0t: no progress, %0d characters still owed", $realtime,
				pending_chars.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Sends one payload byte; called and returns at a falling edge.
	task automatic send_word(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= last;
		do begin
			@(posedge clk);
		end while (!s_axis_tready);
		frame_byte(b, last);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_frame(input int len);
		for (int i = 0; i < len; i++) begin
			send_word(8'($urandom_range(255)), i == len - 1);
		end
	endtask

	// Stops sending and waits until every owed character has come out.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending_chars.size() != 0) begin
			@(negedge clk);
		end
		repeat (SettleCycles) @(negedge clk);
	endtask

	// Writes the length limit; the block must be idle.
	task automatic write_limit(input logic [15:0] value);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		line_limit = value;
		limits_used++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Reset limit of 1016: ordinary frames and a single byte frame pass whole.
	task automatic test_reset_limit();
		send_frame(12);
		send_word(8'h5A, 1'b1);
		send_frame(5);
		drain();
	endtask

	// Hand-picked frames around small limits and the CRC check string.
	task automatic test_directed_frames();
		string check_str;
		check_str = "123456789";
		write_limit(16'd3);
		send_word(8'h00, 1'b1);
		send_word(8'hFF, 1'b1);
		send_word(8'hA5, 1'b0);
		send_word(8'h5A, 1'b0);
		send_word(8'hC3, 1'b1);
		// Fourth byte is cut; the rest up to the last mark is dropped.
		send_word(8'h01, 1'b0);
		send_word(8'h02, 1'b0);
		send_word(8'h03, 1'b0);
		send_word(8'h04, 1'b0);
		send_word(8'h05, 1'b0);
		send_word(8'h06, 1'b1);
		send_word(8'h80, 1'b1);
		write_limit(16'd1);
		send_word(8'h7E, 1'b0);
		send_word(8'h81, 1'b1);
		send_word(8'h00, 1'b1);
		write_limit(16'd9);
		for (int i = 0; i < check_str.len(); i++) begin
			send_word(check_str[i], i == check_str.len() - 1);
		end
		drain();
	endtask

	// Mostly well-formed frames, some too long, some with random last marks.
	task automatic run_random_frames(input int n_items);
		int sent;
		int len;
		int kind;
		sent = 0;
		while (sent < n_items) begin
			kind = $urandom_range(9);
			if (kind == 9) begin
				len = $urandom_range(6, 1);
				for (int i = 0; i < len; i++) begin
					send_word(8'($urandom_range(255)), 1'($urandom_range(1)));
				end
			end else begin
				if (kind >= 7 && line_limit <= 16) begin
					len = int'(line_limit) + $urandom_range(4, 1);
				end else if (line_limit <= 12) begin
					len = $urandom_range(int'(line_limit), 1);
				end else begin
					len = $urandom_range(12, 1);
				end
				send_frame(len);
			end
			sent += len;
		end
	endtask

	task automatic test_slow_receiver();
		send_idle_pct = 18;
		recv_stall_pct = 54;
		write_limit(16'($urandom_range(6, 2)));
		run_random_frames(90);
	endtask

	task automatic test_slow_sender();
		send_idle_pct = 54;
		recv_stall_pct = 18;
		write_limit(16'hFFFF);
		run_random_frames(90);
	endtask

	// Full rate, with a pause until the output side is empty halfway.
	task automatic test_full_rate();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		write_limit(16'd1);
		run_random_frames(44);
		drain();
		write_limit(16'($urandom_range(10, 3)));
		run_random_frames(44);
	endtask

	initial begin
		line_limit = MaxLenReset;
		line_dropping = 1'b0;
		restart_line();
		repeat (ResetCycles) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_limit();
		test_directed_frames();
		test_slow_receiver();
		test_slow_sender();
		test_full_rate();

		drain();
		mismatches += pending_chars.size();
		$display("Sent %0d payload bytes, checked %0d characters under %0d limit settings.",
			bytes_sent, chars_checked, limits_used);
		$display("Closed %0d lines and cut %0d over-long frames; %0d mismatches.",
			lines_closed, frames_cut, mismatches);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
